@@ rtl/aibl_pkg.sv @@
// Shared constants, codes and types for the active index bitmap lister.
`default_nettype none
package aibl_pkg;

   // Bitmap geometry
   localparam int MAX_SENONES = 8192;
   localparam int WORD_BITS   = 32;
   localparam int NUM_WORDS   = MAX_SENONES / WORD_BITS;
   localparam int WORD_AW     = $clog2(NUM_WORDS);
   localparam int BIT_AW      = $clog2(WORD_BITS);

   // Field widths
   localparam int IDX_W = 13;
   localparam int CNT_W = 14;

   // Request opcodes
   typedef enum logic [1:0] {
      OP_MARK   = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_REWIND = 2'd2,
      OP_FETCH  = 2'd3
   } opcode_type;

   // Control from the lister to the bitmap store
   typedef struct packed {
      logic                 rd_en;
      logic [WORD_AW-1:0]   rd_addr;
      logic                 wr_en;
      logic [WORD_AW-1:0]   wr_addr;
      logic [WORD_BITS-1:0] wr_data;
      logic                 clear;
   } ram_req_type;

endpackage
`default_nettype wire

@@ rtl/aibl_channels.sv @@
// Valid/ready channel interfaces for requests, responses and the csr write.
`default_nettype none
interface aibl_req_if import aibl_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       opcode;
   logic [IDX_W-1:0] senone_index;

   modport source (output valid, opcode, senone_index, input ready);
   modport sink   (input valid, opcode, senone_index, output ready);
endinterface

interface aibl_rsp_if import aibl_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] active_index;
   logic [CNT_W-1:0] list_position;
   logic             found;
   logic             done_res;

   modport source (output valid, active_index, list_position, found, done_res, input ready);
   modport sink   (input valid, active_index, list_position, found, done_res, output ready);
endinterface

interface aibl_csr_if import aibl_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ rtl/aibl_bitmap_ram.sv @@
// Bitmap word store: one synchronous memory plus per-word valid flags.
`default_nettype none
module aibl_bitmap_ram import aibl_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ram_req_type          ram_req,
   output      logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [NUM_WORDS-1:0] word_valid_ff;
   logic [WORD_BITS-1:0] rd_data_ff;

   // Valid flags: a word never written since reset or clear reads as zero
   always_ff @(posedge clock) begin
      if (reset || ram_req.clear) begin
         word_valid_ff <= '0;
      end else if (ram_req.wr_en) begin
         word_valid_ff[ram_req.wr_addr] <= 1'b1;
      end
   end

   // Write port
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // Registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= word_valid_ff[ram_req.rd_addr] ? mem[ram_req.rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/active_index_bitmap_lister_top.sv @@
// Top level of the active index bitmap lister: request decode, scan sequencer, csr.
`default_nettype none
// Keeps one active bit per senone index in a 256 x 32 bit memory and lists the
// marked indices in ascending order. Every request beat yields one response beat.
// Rewind and clear answer straight from idle; clear needs no clearing pass, since the
// per-word valid flags reset at once (also none after reset). Mark reads the word,
// then modifies and writes it back; a mark at or above the limit answers at once.
// Fetch reads one word per cycle from the single memory read port until it finds a
// hit at or past the cursor or runs out of indices at the limit; a fetch with the
// cursor at or past the limit answers at once.
// A new request is taken only when the response register is empty or its beat
// leaves in the same cycle; the block then takes no further request until its own
// response has been written.
module active_index_bitmap_lister_top import aibl_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   aibl_req_if.sink   req_bus,
   aibl_rsp_if.source rsp_bus,
   aibl_csr_if.sink   csr_bus
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MARK,
      ST_SCAN
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     senones_ff, senones_in;
   logic [CNT_W-1:0]     cursor_ff, cursor_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic [IDX_W-1:0]     mark_idx_ff, mark_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [CNT_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic                 rsp_done_ff, rsp_done_in;

   ram_req_type          ram_req;
   logic [WORD_BITS-1:0] rd_data;

   logic [CNT_W-1:0]     limit;
   logic                 slot_free;
   logic                 req_fire;
   opcode_type           opcode;
   logic [WORD_BITS-1:0] masked_word;
   logic [BIT_AW-1:0]    tz;
   logic [CNT_W-1:0]     hit_idx;
   logic [CNT_W-1:0]     next_word_idx;

   // Lowest set bit of a nonzero word
   function automatic logic [BIT_AW-1:0] lowest_set(input logic [WORD_BITS-1:0] word);
      logic [BIT_AW-1:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (word[i]) begin
            pos = BIT_AW'(i);
         end
      end
      return pos;
   endfunction

   aibl_bitmap_ram u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // Handshakes
   assign limit         = (senones_ff > CNT_W'(MAX_SENONES)) ? CNT_W'(MAX_SENONES) : senones_ff;
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign opcode        = opcode_type'(req_bus.opcode);
   assign csr_bus.ready = 1'b1;

   // Scan datapath: drop bits below the scan position, then find the first hit
   assign masked_word   = rd_data & ({WORD_BITS{1'b1}} << scan_ff[BIT_AW-1:0]);
   assign tz            = lowest_set(masked_word);
   assign hit_idx       = {1'b0, scan_ff[IDX_W-1:BIT_AW], tz};
   assign next_word_idx = {(WORD_AW + 1)'({1'b0, scan_ff[IDX_W-1:BIT_AW]} + 1'b1),
                           {BIT_AW{1'b0}}};

   // Next-state and response logic
   always_comb begin
      state_in     = state_ff;
      senones_in   = senones_ff;
      cursor_in    = cursor_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      mark_idx_in  = mark_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_index_in = rsp_index_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_found_in = rsp_found_ff;
      rsp_done_in  = rsp_done_ff;
      ram_req      = '0;

      if (csr_bus.valid) begin
         senones_in = csr_bus.data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (opcode)
                  OP_MARK: begin
                     if (CNT_W'(req_bus.senone_index) < limit) begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = req_bus.senone_index[IDX_W-1:BIT_AW];
                        mark_idx_in     = req_bus.senone_index;
                        state_in        = ST_MARK;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_index_in = '0;
                        rsp_pos_in   = count_ff;
                        rsp_found_in = 1'b0;
                        rsp_done_in  = 1'b0;
                     end
                  end
                  OP_CLEAR, OP_REWIND: begin
                     ram_req.clear = (opcode == OP_CLEAR);
                     cursor_in     = '0;
                     count_in      = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_index_in  = '0;
                     rsp_pos_in    = '0;
                     rsp_found_in  = 1'b0;
                     rsp_done_in   = 1'b0;
                  end
                  OP_FETCH: begin
                     if (cursor_ff < limit) begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = cursor_ff[IDX_W-1:BIT_AW];
                        scan_in         = cursor_ff;
                        state_in        = ST_SCAN;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_index_in = '0;
                        rsp_pos_in   = count_ff;
                        rsp_found_in = 1'b0;
                        rsp_done_in  = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Read data is in: set the bit and write the word back
         ST_MARK: begin
            if (slot_free) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = mark_idx_ff[IDX_W-1:BIT_AW];
               ram_req.wr_data = rd_data | (WORD_BITS'(1) << mark_idx_ff[BIT_AW-1:0]);
               rsp_valid_in    = 1'b1;
               rsp_index_in    = '0;
               rsp_pos_in      = count_ff;
               rsp_found_in    = 1'b0;
               rsp_done_in     = 1'b0;
               state_in        = ST_IDLE;
            end
         end

         // One word per cycle until a hit or the limit
         ST_SCAN: begin
            if (slot_free) begin
               if (masked_word != '0 && hit_idx < limit) begin
                  rsp_valid_in = 1'b1;
                  rsp_index_in = hit_idx[IDX_W-1:0];
                  rsp_pos_in   = count_ff;
                  rsp_found_in = 1'b1;
                  rsp_done_in  = 1'b0;
                  count_in     = count_ff + 1'b1;
                  cursor_in    = hit_idx + 1'b1;
                  state_in     = ST_IDLE;
               end else if (masked_word == '0 && next_word_idx < limit) begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = next_word_idx[IDX_W-1:BIT_AW];
                  scan_in         = next_word_idx;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_index_in = '0;
                  rsp_pos_in   = count_ff;
                  rsp_found_in = 1'b0;
                  rsp_done_in  = 1'b1;
                  cursor_in    = limit;
                  state_in     = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         senones_ff   <= CNT_W'(MAX_SENONES);
         cursor_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         senones_ff   <= senones_in;
         cursor_ff    <= cursor_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff      <= scan_in;
      mark_idx_ff  <= mark_idx_in;
      rsp_index_ff <= rsp_index_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.active_index  = rsp_index_ff;
   assign rsp_bus.list_position = rsp_pos_ff;
   assign rsp_bus.found         = rsp_found_ff;
   assign rsp_bus.done_res      = rsp_done_ff;

endmodule
`default_nettype wire
